// ----- rtl/core/amvt_pkg.sv -----
// shared types, constants and fixed-point helpers for the affine vertex transform
// no dependencies; every other file in rtl/core refers to this package by scoped names
package amvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int ACC_W     = RND_W + 2;

    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    // input opcodes
    localparam logic [1:0] OP_IDENT = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;   // unused, dropped on entry

    localparam logic [1:0] LAST_ROW = 2'd3;

    localparam logic [15:0] IDENT_MASK = 16'b1000_0100_0010_0001;
    localparam logic signed [WORD_BITS-1:0] FIX_ONE = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

    typedef enum logic [1:0] {
        CMD_IDENT,
        CMD_ROW,
        CMD_COMMIT,
        CMD_POINT
    } t_cmd;

    typedef struct packed {
        t_cmd                        cmd;
        logic [1:0]                  row;
        logic signed [WORD_BITS-1:0] e0;
        logic signed [WORD_BITS-1:0] e1;
        logic signed [WORD_BITS-1:0] e2;
        logic signed [WORD_BITS-1:0] e3;
    } t_item;

    typedef struct packed {
        logic                        clip;
        logic signed [WORD_BITS-1:0] val;
    } t_sat;

    // round half up, then drop the fraction bits (arithmetic)
    function automatic logic signed [RND_W-1:0] mul_rnd(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] t;
        t = p + ROUND_HALF;
        return $signed(t[PROD_W-1:FRAC_BITS]);
    endfunction

    function automatic t_sat sat_word(input logic signed [ACC_W-1:0] acc);
        t_sat s;
        s.clip = 1'b0;
        s.val  = acc[WORD_BITS-1:0];
        if (acc > ACC_MAX) begin
            s.clip = 1'b1;
            s.val  = ACC_MAX[WORD_BITS-1:0];
        end else if (acc < ACC_MIN) begin
            s.clip = 1'b1;
            s.val  = ACC_MIN[WORD_BITS-1:0];
        end
        return s;
    endfunction

endpackage

// ----- rtl/core/amvt_front.sv -----
// front end: takes input beats, decodes the opcode into a queue command
// depends on amvt_pkg
module amvt_front (
    input  logic                                 i_in_valid,
    input  logic [1:0]                           i_opcode,
    input  logic [1:0]                           i_row_index,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_0,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_1,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_2,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_3,
    input  logic                                 i_q_full,
    output logic                                 o_in_stall,
    output logic                                 o_push,
    output amvt_pkg::t_item                      o_item
);

    logic take;
    logic keep;

    assign o_in_stall = i_q_full;
    assign take       = i_in_valid && !i_q_full;

    always_comb begin
        o_item.row = i_row_index;
        o_item.e0  = i_elem_0;
        o_item.e1  = i_elem_1;
        o_item.e2  = i_elem_2;
        o_item.e3  = i_elem_3;
        o_item.cmd = amvt_pkg::CMD_IDENT;
        keep       = 1'b1;
        unique case (i_opcode)
            amvt_pkg::OP_IDENT: o_item.cmd = amvt_pkg::CMD_IDENT;
            amvt_pkg::OP_ROW: begin
                o_item.cmd = (i_row_index == amvt_pkg::LAST_ROW) ? amvt_pkg::CMD_COMMIT
                                                                  : amvt_pkg::CMD_ROW;
            end
            amvt_pkg::OP_POINT: o_item.cmd = amvt_pkg::CMD_POINT;
            default: keep = 1'b0;   // unused opcode, swallowed
        endcase
    end

    assign o_push = take && keep;

endmodule

// ----- rtl/core/amvt_queue.sv -----
// short command queue between front and back end
// depends on amvt_pkg
module amvt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  amvt_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_vld,
    output amvt_pkg::t_item o_head
);

    amvt_pkg::t_item              r_mem [amvt_pkg::Q_DEPTH];
    logic [amvt_pkg::Q_AW-1:0]    r_wp;
    logic [amvt_pkg::Q_AW-1:0]    r_rp;
    logic [amvt_pkg::Q_AW:0]      r_cnt;
    logic                         do_pop;

    assign o_full     = (r_cnt == (amvt_pkg::Q_AW+1)'(amvt_pkg::Q_DEPTH));
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_mem[r_rp];
    assign do_pop     = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (amvt_pkg::Q_AW+1)'(i_push) - (amvt_pkg::Q_AW+1)'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (amvt_pkg::Q_AW+1)'(amvt_pkg::Q_DEPTH))
        else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ----- rtl/core/amvt_back.sv -----
// back end: matrix state, row staging, matrix commit sequencer and point pipeline
// depends on amvt_pkg
module amvt_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_head_vld,
    input  amvt_pkg::t_item                       i_head,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [amvt_pkg::WORD_BITS-1:0] o_out_x,
    output logic signed [amvt_pkg::WORD_BITS-1:0] o_out_y,
    output logic signed [amvt_pkg::WORD_BITS-1:0] o_out_z,
    output logic                                  o_clipped
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DRAIN, S_WRITE} t_state;

    t_state r_state;
    logic [3:0] r_cnt;

    logic signed [amvt_pkg::WORD_BITS-1:0] r_m    [16];
    logic signed [amvt_pkg::WORD_BITS-1:0] r_a    [16];
    logic signed [amvt_pkg::WORD_BITS-1:0] r_mc   [16];
    logic signed [amvt_pkg::WORD_BITS-1:0] r_prod [16];
    logic signed [amvt_pkg::WORD_BITS-1:0] r_pend [3][4];

    logic signed [amvt_pkg::PROD_W-1:0] r_cp [4];
    logic                               r_cp_vld;

    logic signed [amvt_pkg::PROD_W-1:0]    r_pp [3][3];
    logic signed [amvt_pkg::WORD_BITS-1:0] r_pt [3];
    logic                                  r_p1_vld;

    logic                                  r_out_vld;
    logic signed [amvt_pkg::WORD_BITS-1:0] r_ox, r_oy, r_oz;
    logic                                  r_oclip;

    logic signed [amvt_pkg::WORD_BITS-1:0] hd_e [4];
    logic                                  adv;
    logic                                  pop;
    logic                                  pt_issue;
    logic signed [amvt_pkg::ACC_W-1:0]     c_sum;
    amvt_pkg::t_sat                        c_sat;
    logic signed [amvt_pkg::ACC_W-1:0]     p_sum [3];
    amvt_pkg::t_sat                        p_sat [3];

    assign hd_e[0] = i_head.e0;
    assign hd_e[1] = i_head.e1;
    assign hd_e[2] = i_head.e2;
    assign hd_e[3] = i_head.e3;

    assign adv      = !r_out_vld || !i_out_stall;
    assign pop      = i_head_vld && (r_state == S_IDLE)
                      && ((i_head.cmd != amvt_pkg::CMD_POINT) || adv);
    assign pt_issue = pop && (i_head.cmd == amvt_pkg::CMD_POINT);
    assign o_pop    = pop;

    always_comb begin
        c_sum = '0;
        for (int k = 0; k < 4; k++) begin
            c_sum = c_sum + amvt_pkg::ACC_W'(amvt_pkg::mul_rnd(r_cp[k]));
        end
        c_sat = amvt_pkg::sat_word(c_sum);
        for (int i = 0; i < 3; i++) begin
            p_sum[i] = amvt_pkg::ACC_W'(r_pt[i]);
            for (int k = 0; k < 3; k++) begin
                p_sum[i] = p_sum[i] + amvt_pkg::ACC_W'(amvt_pkg::mul_rnd(r_pp[i][k]));
            end
            p_sat[i] = amvt_pkg::sat_word(p_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_cp_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_m[i] <= amvt_pkg::IDENT_MASK[i] ? amvt_pkg::FIX_ONE : '0;
            end
        end else begin
            r_cp_vld <= (r_state == S_MUL);

            // point pipeline: products, then round/sum/saturate into output reg
            if (adv) begin
                r_p1_vld  <= pt_issue;
                r_out_vld <= r_p1_vld;
                for (int i = 0; i < 3; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_pp[i][k] <= r_m[i*4+k] * hd_e[k];
                    end
                    r_pt[i] <= r_m[i*4+3];
                end
                if (r_p1_vld) begin
                    r_ox    <= p_sat[0].val;
                    r_oy    <= p_sat[1].val;
                    r_oz    <= p_sat[2].val;
                    r_oclip <= p_sat[0].clip || p_sat[1].clip || p_sat[2].clip;
                end
            end

            // finished matrix entries shift in, entry 0 ends up in slot 0
            if (r_cp_vld) begin
                for (int i = 0; i < 15; i++) begin
                    r_prod[i] <= r_prod[i+1];
                end
                r_prod[15] <= c_sat.val;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        case (i_head.cmd)
                            amvt_pkg::CMD_IDENT: begin
                                for (int i = 0; i < 16; i++) begin
                                    r_m[i] <= amvt_pkg::IDENT_MASK[i] ? amvt_pkg::FIX_ONE : '0;
                                end
                            end
                            amvt_pkg::CMD_ROW: begin
                                for (int c = 0; c < 4; c++) begin
                                    r_pend[i_head.row][c] <= hd_e[c];
                                end
                            end
                            amvt_pkg::CMD_COMMIT: begin
                                for (int r = 0; r < 3; r++) begin
                                    for (int c = 0; c < 4; c++) begin
                                        r_a[r*4+c] <= r_pend[r][c];
                                    end
                                end
                                for (int c = 0; c < 4; c++) begin
                                    r_a[12+c] <= hd_e[c];
                                end
                                r_mc    <= r_m;
                                r_cnt   <= '0;
                                r_state <= S_MUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    // row 0 of A against column 0 of M, then rotate both into place
                    for (int k = 0; k < 4; k++) begin
                        r_cp[k] <= r_a[k] * r_mc[k*4];
                    end
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            r_mc[r*4+c] <= r_mc[r*4+((c+1)%4)];
                        end
                    end
                    if (&r_cnt[1:0]) begin
                        for (int r = 0; r < 4; r++) begin
                            for (int c = 0; c < 4; c++) begin
                                r_a[r*4+c] <= r_a[((r+1)%4)*4+c];
                            end
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_WRITE;
                S_WRITE: begin
                    r_m     <= r_prod;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_clipped   = r_oclip;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("issue while commit in progress");
    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_DRAIN))
        else $error("matrix write out of sequence");
    a_cp_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> ($past(r_state) == S_MUL))
        else $error("product lane valid without multiply step");
    a_point_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_vld && r_out_vld && i_out_stall) |=> (r_p1_vld && $stable(r_pt[0])))
        else $error("point pipeline stage overwritten under stall");

endmodule

// ----- rtl/core/affine_matrix_vertex_transform.sv -----
// top level of the affine 4x4 vertex transform
// depends on amvt_pkg, amvt_front, amvt_queue, amvt_back
//
// The block holds a 4x4 model matrix in signed Q16.16 (identity after reset)
// and takes a stream of beats: load identity, matrix rows (rows 0..2 are
// staged, row 3 commits M := A * M), and points (x,y,z,w=1) that come back
// as transformed x,y,z plus a clip flag when any coordinate saturated.
// Points flow at one per cycle while no commit runs and the output is not
// stalled: nine 32x32 multipliers form all products in one stage and a
// second stage rounds, sums and saturates into the output register.
// A commit runs on a separate four-lane dot-product unit, one matrix entry
// per cycle, and holds the back end through issue, 16 entries, drain and
// write; the 4-deep command queue keeps taking beats meanwhile until full.
// Identity and row beats are taken by the back end on issue and give no result.
// Opcode 3 is accepted and dropped.
module affine_matrix_vertex_transform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_opcode,
    input  logic [1:0]                            i_row_index,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_0,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_1,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_2,
    input  logic signed [amvt_pkg::WORD_BITS-1:0] i_elem_3,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [amvt_pkg::WORD_BITS-1:0] o_out_x,
    output logic signed [amvt_pkg::WORD_BITS-1:0] o_out_y,
    output logic signed [amvt_pkg::WORD_BITS-1:0] o_out_z,
    output logic                                  o_clipped
);

    logic            q_full;
    logic            push;
    amvt_pkg::t_item push_item;
    logic            head_vld;
    amvt_pkg::t_item head;
    logic            pop;

    // decode and admission
    amvt_front u_front (
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_row_index (i_row_index),
        .i_elem_0    (i_elem_0),
        .i_elem_1    (i_elem_1),
        .i_elem_2    (i_elem_2),
        .i_elem_3    (i_elem_3),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_item      (push_item)
    );

    // decouples the front from commit stalls and output back-pressure
    amvt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_head_vld (head_vld),
        .o_head     (head)
    );

    // execution: matrix state, commit unit, point pipeline
    amvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_vld  (head_vld),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_clipped   (o_clipped)
    );

endmodule
